/* design/sda_pkg.sv */
`timescale 1ns / 1ps
// sda_pkg: shared types and constants of the spike delay accumulator.
// Used by the register block, controller, datapath and top level.
package sda_pkg;

  // input action codes
  localparam logic [1:0] ACT_FIRE  = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // register indexes, 64-bit registers at byte address 8*index
  localparam logic [2:0] REG_SHAPE_LEN = 3'd0;
  localparam logic [2:0] REG_SHAPE_A   = 3'd1;
  localparam logic [2:0] REG_SHAPE_B   = 3'd2;
  localparam logic [2:0] REG_SHAPE_C   = 3'd3;
  localparam logic [2:0] REG_SHAPE_D   = 3'd4;
  localparam logic [2:0] REG_SHUNT     = 3'd5;

  localparam int ADDR_W      = 6;
  localparam int DATA_W      = 64;
  localparam int CELL_W      = 6;
  localparam int ACC_W       = 24;
  localparam int SAMPLE_W    = 16;
  localparam int SAMPLE_MAX  = 16;
  localparam int SAMPLES_W   = SAMPLE_W * SAMPLE_MAX;

  localparam logic signed [ACC_W:0] ACC_MAX = 25'sd8388607;
  localparam logic signed [ACC_W:0] ACC_MIN = -25'sd8388608;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_DECODE,
    S_FIRE,
    S_DRAIN,
    S_TICK
  } sda_state_t;

  typedef struct packed {
    logic load;
    logic fire_step;
    logic tick_step;
    logic sweep_wr;
    logic advance;
  } sda_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       fire_ok;
    logic       step_ok;
    logic       last_cell;
    logic       credit_ok;
    logic       pipe_busy;
  } sda_stat_t;

  typedef struct packed {
    logic [CELL_W-1:0]       cell_id;
    logic signed [ACC_W-1:0] pot;
    logic                    shunt;
    logic                    last;
  } sda_res_t;

endpackage

/* design/sda_regs.sv */
`timescale 1ns / 1ps
// sda_regs: apb-style configuration registers (shape length, samples, shunting mode).
// Depends on sda_pkg for register indexes and widths.
module sda_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sda_pkg::ADDR_W-1:0]  paddr,
  input  logic [sda_pkg::DATA_W-1:0]  pwdata,
  output logic [sda_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output logic [4:0]                  shape_len,
  output logic [sda_pkg::SAMPLES_W-1:0] shape_samples,
  output logic                        shunt_mode
);
  import sda_pkg::*;

  logic [4:0]        len_r;
  logic [DATA_W-1:0] shape_a_r, shape_b_r, shape_c_r, shape_d_r;
  logic              shunt_r;
  logic [2:0]        reg_idx;
  logic              wr_en;

  assign reg_idx = paddr[ADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= 5'd1;
      shape_a_r <= '0;
      shape_b_r <= '0;
      shape_c_r <= '0;
      shape_d_r <= '0;
      shunt_r   <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SHAPE_LEN: len_r     <= pwdata[4:0];
        REG_SHAPE_A:   shape_a_r <= pwdata;
        REG_SHAPE_B:   shape_b_r <= pwdata;
        REG_SHAPE_C:   shape_c_r <= pwdata;
        REG_SHAPE_D:   shape_d_r <= pwdata;
        REG_SHUNT:     shunt_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SHAPE_LEN: prdata = DATA_W'(len_r);
      REG_SHAPE_A:   prdata = shape_a_r;
      REG_SHAPE_B:   prdata = shape_b_r;
      REG_SHAPE_C:   prdata = shape_c_r;
      REG_SHAPE_D:   prdata = shape_d_r;
      REG_SHUNT:     prdata = DATA_W'(shunt_r);
      default:       prdata = '0;
    endcase
  end

  assign shape_len     = len_r;
  assign shape_samples = {shape_d_r, shape_c_r, shape_b_r, shape_a_r};
  assign shunt_mode    = shunt_r;

endmodule

/* design/sda_ctrl.sv */
`timescale 1ns / 1ps
// sda_ctrl: sequencer for item accept, fire steps, tick readout and memory sweeps.
// Depends on sda_pkg for the state type and the command/status structs.
module sda_ctrl #(
  parameter int AW = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sda_pkg::sda_stat_t  stat,
  output sda_pkg::sda_cmd_t   cmd,
  output logic [AW-1:0]       cnt
);
  import sda_pkg::*;

  sda_state_t    state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_SWEEP: begin
        if (&cnt_r) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (stat.action)
          ACT_FIRE:  state_nxt = stat.fire_ok ? S_FIRE : S_IDLE;
          ACT_TICK:  state_nxt = S_TICK;
          ACT_CLEAR: state_nxt = S_SWEEP;
          default:   state_nxt = S_IDLE;
        endcase
      end
      S_FIRE: begin
        if (!stat.step_ok) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) state_nxt = S_IDLE;
      end
      S_TICK: begin
        if (stat.credit_ok && stat.last_cell) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cnt_nxt  = cnt_r;
    in_stall = 1'b1;
    case (state_r)
      S_SWEEP: begin
        cmd.sweep_wr = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
        cnt_nxt  = '0;
      end
      S_FIRE: begin
        if (stat.step_ok) begin
          cmd.fire_step = 1'b1;
          cnt_nxt       = cnt_r + 1'b1;
        end
      end
      S_TICK: begin
        // only issue a read when the output buffer has room for it
        if (stat.credit_ok) begin
          cmd.tick_step = 1'b1;
          cmd.advance   = stat.last_cell;
          cnt_nxt       = cnt_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign cnt = cnt_r;

endmodule

/* design/sda_dp.sv */
`timescale 1ns / 1ps
// sda_dp: frame memory, fire multiply-accumulate pipeline, frame pointer and output buffer.
// Depends on sda_pkg for the command/status/result structs and constants.
module sda_dp #(
  parameter int FRAMES = 16,
  parameter int CELLS  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sda_pkg::sda_cmd_t                 cmd,
  input  logic [((CELLS > 1) ? $clog2(CELLS) : 1) + $clog2(FRAMES) - 1:0] cnt,
  output sda_pkg::sda_stat_t                stat,
  input  logic [1:0]                        in_action,
  input  logic [sda_pkg::CELL_W-1:0]        in_cell_index,
  input  logic signed [15:0]                in_weight,
  input  logic [3:0]                        in_delay,
  input  logic [4:0]                        shape_len,
  input  logic [sda_pkg::SAMPLES_W-1:0]     shape_samples,
  input  logic                              shunt_mode,
  output logic                              out_valid,
  input  logic                              out_stall,
  output sda_pkg::sda_res_t                 out_res
);
  import sda_pkg::*;

  localparam int FW    = $clog2(FRAMES);
  localparam int CW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int AW    = FW + CW;
  localparam int DEPTH = 1 << AW;
  localparam int KW    = AW + 5;

  // held item
  logic [1:0]         act_r;
  logic [CELL_W-1:0]  cell_r;
  logic signed [15:0] w_r;
  logic [3:0]         dly_r;
  logic [FW-1:0]      frame_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_action;
      cell_r <= in_cell_index;
      w_r    <= in_weight;
      dly_r  <= in_delay;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r <= '0;
    end else if (cmd.advance) begin
      frame_r <= (frame_r == FW'(FRAMES - 1)) ? '0 : frame_r + 1'b1;
    end
  end

  // fire step: sample k lands in frame (current + delay + k) mod FRAMES
  logic [4:0]          len_eff;
  logic [KW-1:0]       k_w, ahead;
  logic [FW:0]         fsum;
  logic [FW-1:0]       tframe;
  logic [AW-1:0]       fire_addr, tick_addr;
  logic signed [15:0]  smp;

  assign len_eff   = (shape_len > 5'd16) ? 5'd16 : shape_len;
  assign k_w       = KW'(cnt);
  assign ahead     = KW'(dly_r) + k_w;
  assign fsum      = (FW + 1)'(frame_r) + ahead[FW:0];
  assign tframe    = (fsum >= (FW + 1)'(FRAMES)) ? FW'(fsum - (FW + 1)'(FRAMES)) : fsum[FW-1:0];
  assign fire_addr = {tframe, cell_r[CW-1:0]};
  assign tick_addr = {frame_r, cnt[CW-1:0]};
  assign smp       = shape_samples[{k_w[3:0], 4'b0000} +: SAMPLE_W];

  // frame memory, read-first
  logic [ACC_W-1:0]        frame_mem [DEPTH];
  logic signed [ACC_W-1:0] rdata_r;
  logic                    mem_re, mem_we;
  logic [AW-1:0]           mem_raddr, mem_waddr;
  logic [ACC_W-1:0]        mem_wdata;

  // fire pipeline
  logic                    fv1_r, fv2_r;
  logic signed [31:0]      prod_r;
  logic signed [31:0]      rsum;
  logic signed [17:0]      sc_r;
  logic signed [ACC_W-1:0] old_r;
  logic [AW-1:0]           fa1_r, fa2_r;
  logic signed [ACC_W:0]   acc_sum;
  logic [ACC_W-1:0]        acc_sat;

  assign rsum    = prod_r + 32'sd8192;
  assign acc_sum = (ACC_W + 1)'(old_r) + (ACC_W + 1)'(sc_r);

  always_comb begin
    if (acc_sum > ACC_MAX) begin
      acc_sat = ACC_MAX[ACC_W-1:0];
    end else if (acc_sum < ACC_MIN) begin
      acc_sat = ACC_MIN[ACC_W-1:0];
    end else begin
      acc_sat = acc_sum[ACC_W-1:0];
    end
  end

  always_comb begin
    mem_re    = cmd.fire_step || cmd.tick_step;
    mem_raddr = cmd.fire_step ? fire_addr : tick_addr;
    mem_we    = 1'b0;
    mem_waddr = tick_addr;
    mem_wdata = '0;
    if (cmd.sweep_wr) begin
      mem_we    = 1'b1;
      mem_waddr = cnt;
    end else if (cmd.tick_step) begin
      // the delivered entry is zeroed as it is read
      mem_we    = 1'b1;
      mem_waddr = tick_addr;
    end else if (fv2_r) begin
      mem_we    = 1'b1;
      mem_waddr = fa2_r;
      mem_wdata = acc_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) rdata_r <= frame_mem[mem_raddr];
    if (mem_we) frame_mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv1_r <= 1'b0;
      fv2_r <= 1'b0;
    end else begin
      fv1_r <= cmd.fire_step;
      fv2_r <= fv1_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= w_r * smp;
    fa1_r  <= fire_addr;
    sc_r   <= rsum[31:14];
    old_r  <= rdata_r;
    fa2_r  <= fa1_r;
  end

  // tick readout into a two-entry output buffer
  logic              tv_r;
  logic [CW-1:0]     tcell_r;
  logic              tlast_r, tshunt_r;
  logic              last_cell;
  sda_res_t          push_res;
  sda_res_t          slot0_r, slot1_r;
  logic [1:0]        ocnt_r;
  logic              pop;
  logic [2:0]        occ;

  assign last_cell = (cnt[CW-1:0] == CW'(CELLS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r <= 1'b0;
    end else begin
      tv_r <= cmd.tick_step;
    end
  end

  always_ff @(posedge clk) begin
    tcell_r  <= cnt[CW-1:0];
    tlast_r  <= last_cell;
    tshunt_r <= shunt_mode;
  end

  assign push_res.cell_id = CELL_W'(tcell_r);
  assign push_res.pot     = rdata_r;
  assign push_res.shunt   = tshunt_r;
  assign push_res.last    = tlast_r;

  assign out_valid = (ocnt_r != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign out_res   = slot0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocnt_r <= 2'd0;
    end else begin
      ocnt_r <= ocnt_r + {1'b0, tv_r} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (tv_r && ocnt_r == 2'd1) begin
        slot0_r <= push_res;
      end else begin
        slot0_r <= slot1_r;
        if (tv_r) slot1_r <= push_res;
      end
    end else if (tv_r) begin
      if (ocnt_r == 2'd0) begin
        slot0_r <= push_res;
      end else begin
        slot1_r <= push_res;
      end
    end
  end

  // buffered + in flight - leaving must stay at one or less before a new read
  assign occ = 3'(ocnt_r) + 3'(tv_r);

  assign stat.action    = act_r;
  assign stat.fire_ok   = ({1'b0, cell_r} < 7'(CELLS));
  assign stat.step_ok   = (k_w < KW'(len_eff)) && (ahead < KW'(FRAMES));
  assign stat.last_cell = last_cell;
  assign stat.credit_ok = (occ <= (pop ? 3'd2 : 3'd1));
  assign stat.pipe_busy = fv1_r || fv2_r;

endmodule

/* design/spike_delay_accumulator.sv */
`timescale 1ns / 1ps
// spike_delay_accumulator: top level joining registers, controller and datapath.
// Depends on sda_pkg, sda_regs, sda_ctrl and sda_dp.

// A ring of FRAMES time frames, each with one saturating Q16.8 accumulator per cell,
// kept in a single frame memory with one read and one write port. Items are taken one
// at a time. A fire item is accepted and decoded, then steps once per shape sample that
// lands inside the ring (at most shape_length) and drains the multiply/round/accumulate
// pipeline. A tick item makes one memory read per cell, delivering results in cell
// order with last on the final cell; a stalled output slows this once the two-entry
// output buffer, with the read in flight, is full. Each delivered entry is zeroed as
// it is read, then the ring advances. A clear item, and reset itself, sweep the whole
// memory one entry per cycle; no item is accepted during the sweep, while register
// writes are taken at any time.
module spike_delay_accumulator #(
  parameter int FRAMES = 16,
  parameter int CELLS  = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_action,
  input  logic [5:0]                     in_cell_index,
  input  logic signed [15:0]             in_weight,
  input  logic [3:0]                     in_delay,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [5:0]                     out_cell_res,
  output logic signed [23:0]             out_potential,
  output logic                           out_is_shunt,
  output logic                           out_last,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sda_pkg::ADDR_W-1:0]     paddr,
  input  logic [sda_pkg::DATA_W-1:0]     pwdata,
  output logic [sda_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);
  import sda_pkg::*;

  localparam int FW = $clog2(FRAMES);
  localparam int CW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int AW = FW + CW;

  logic [4:0]           shape_len;
  logic [SAMPLES_W-1:0] shape_samples;
  logic                 shunt_mode;
  sda_cmd_t             cmd;
  sda_stat_t            stat;
  logic [AW-1:0]        cnt;
  sda_res_t             out_res;

  sda_regs u_regs (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .shape_len     (shape_len),
    .shape_samples (shape_samples),
    .shunt_mode    (shunt_mode)
  );

  sda_ctrl #(
    .AW (AW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd),
    .cnt      (cnt)
  );

  sda_dp #(
    .FRAMES (FRAMES),
    .CELLS  (CELLS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .cnt           (cnt),
    .stat          (stat),
    .in_action     (in_action),
    .in_cell_index (in_cell_index),
    .in_weight     (in_weight),
    .in_delay      (in_delay),
    .shape_len     (shape_len),
    .shape_samples (shape_samples),
    .shunt_mode    (shunt_mode),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_res       (out_res)
  );

  assign out_cell_res  = out_res.cell_id;
  assign out_potential = out_res.pot;
  assign out_is_shunt  = out_res.shunt;
  assign out_last      = out_res.last;

  // no new item while a fire update is still in the pipeline
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !stat.pipe_busy)
    else $error("item accepted with fire pipeline busy");

  // a tick read is only issued when the output buffer can take it
  a_tick_credit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tick_step |-> stat.credit_ok && !cmd.fire_step && !cmd.sweep_wr)
    else $error("tick read without buffer room or with a conflicting access");

  // the last marker belongs to the final cell only
  a_last_cell: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_cell_res == 6'(CELLS - 1))
    else $error("last marker on a cell other than the final one");

  // the ring advances only on the final tick read
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.advance |-> cmd.tick_step && stat.last_cell)
    else $error("frame advanced outside the final tick read");

endmodule

/* dv/tb_spike_delay_accumulator.sv */
`timescale 1ns / 1ps
// tb_spike_delay_accumulator: self-checking testbench for the spike delay accumulator.
// Depends on sda_pkg and spike_delay_accumulator; keeps its own copy of the frame ring
// and checks every delivered cell against it.
module tb_spike_delay_accumulator;
  import sda_pkg::*;

  localparam int FRAMES = 16;
  localparam int CELLS  = 16;
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  // a clear, which sweeps the whole memory, is the longest item in flight
  localparam int SETTLE_CYCLES = 300;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_action = ACT_FIRE;
  logic [5:0] in_cell_index = '0;
  logic signed [15:0] in_weight = '0;
  logic [3:0] in_delay = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [5:0] out_cell_res;
  logic signed [23:0] out_potential;
  logic out_is_shunt;
  logic out_last;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  spike_delay_accumulator #(.FRAMES(FRAMES), .CELLS(CELLS)) dut (.*);

  // predicted state of the block
  logic signed [ACC_W-1:0] ring_acc [FRAMES][CELLS];
  int ring_head;
  logic [4:0] shape_len_q;
  logic [63:0] shape_q [4];
  logic shunt_q;
  sda_res_t pending_deliveries [$];

  int mismatches = 0;
  int sender_idle_pct = 0;
  int stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_spike_delay_accumulator: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : check_deliveries
    sda_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_deliveries.size() == 0) begin
        note_mismatch($sformatf("unexpected item cell %0d potential %0d",
                                out_cell_res, out_potential));
      end else begin
        want = pending_deliveries.pop_front();
        if (out_cell_res !== want.cell_id || out_potential !== want.pot ||
            out_is_shunt !== want.shunt || out_last !== want.last) begin
          note_mismatch($sformatf(
            "expected cell %0d pot %0d shunt %0b last %0b, got %0d %0d %0b %0b",
            want.cell_id, want.pot, want.shunt, want.last,
            out_cell_res, out_potential, out_is_shunt, out_last));
        end
      end
    end
  end

  function automatic logic signed [15:0] shape_sample(input int k);
    return shape_q[k >> 2][(k & 3) * 16 +: 16];
  endfunction

  // weight * sample is Q10.22, rounded half up to Q.8, then saturating add
  function automatic logic signed [ACC_W-1:0] sat_accumulate(
      input logic signed [ACC_W-1:0] acc, input logic signed [15:0] w,
      input logic signed [15:0] s);
    logic signed [31:0] prod;
    logic signed [31:0] sum;
    prod = w * s;
    sum = acc + ((prod + 32'sd8192) >>> 14);
    if (sum > ACC_MAX) return 24'sh7FFFFF;
    if (sum < ACC_MIN) return 24'sh800000;
    return sum[ACC_W-1:0];
  endfunction

  task automatic clear_ring();
    foreach (ring_acc[f, c]) ring_acc[f][c] = '0;
  endtask

  task automatic spread_spike(input logic [5:0] cell_idx, input logic signed [15:0] w,
                              input logic [3:0] d);
    int len;
    int ahead;
    int f;
    len = (shape_len_q > 16) ? 16 : shape_len_q;
    if (cell_idx >= CELLS) return;
    for (int k = 0; k < len; k++) begin
      ahead = d + k;
      // samples past one turn of the ring are dropped
      if (ahead >= FRAMES) break;
      f = (ring_head + ahead) % FRAMES;
      ring_acc[f][cell_idx] = sat_accumulate(ring_acc[f][cell_idx], w, shape_sample(k));
    end
  endtask

  task automatic deliver_frame();
    sda_res_t res;
    for (int c = 0; c < CELLS; c++) begin
      res.cell_id = c[CELL_W-1:0];
      res.pot = ring_acc[ring_head][c];
      res.shunt = shunt_q;
      res.last = (c == CELLS - 1);
      pending_deliveries.push_back(res);
      ring_acc[ring_head][c] = '0;
    end
    ring_head = (ring_head + 1) % FRAMES;
  endtask

  task automatic send_item(input logic [1:0] act, input logic [5:0] cell_idx,
                           input logic signed [15:0] w, input logic [3:0] d);
    if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_cell_index <= cell_idx;
    in_weight <= w;
    in_delay <= d;
    do @(posedge clk); while (in_stall);
    case (act)
      ACT_FIRE:  spread_spike(cell_idx, w, d);
      ACT_TICK:  deliver_frame();
      ACT_CLEAR: clear_ring();
      default: ;
    endcase
  endtask

  task automatic tick();
    send_item(ACT_TICK, 6'($urandom), 16'($urandom), 4'($urandom));
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SHAPE_LEN: shape_len_q = val[4:0];
      REG_SHAPE_A, REG_SHAPE_B, REG_SHAPE_C, REG_SHAPE_D: shape_q[idx - REG_SHAPE_A] = val;
      REG_SHUNT: shunt_q = val[0];
      default: ;
    endcase
  endtask

  // every sample drawn from lo..hi
  task automatic load_shape(input int lo, input int hi);
    logic [63:0] v;
    for (int r = 0; r < 4; r++) begin
      for (int j = 0; j < 4; j++) v[16*j +: 16] = 16'($urandom_range(lo, hi));
      write_reg(3'(REG_SHAPE_A + r), v);
    end
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_deliveries.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed_basics();
    write_reg(REG_SHAPE_LEN, 64'd4);
    // samples -2.0, max, smallest step, -1.0
    write_reg(REG_SHAPE_A, 64'hC000_0001_7FFF_8000);
    write_reg(REG_SHUNT, 64'd1);
    send_item(ACT_FIRE, 6'd0, 16'sh7FFF, 4'd0);
    send_item(ACT_FIRE, 6'd15, 16'sh8000, 4'd0);
    send_item(ACT_FIRE, 6'd3, 16'sd1, 4'd15);
    send_item(ACT_FIRE, 6'd7, -16'sd1, 4'd13);
    // cells outside the ring are ignored
    send_item(ACT_FIRE, 6'd63, 16'sd100, 4'd0);
    send_item(ACT_FIRE, 6'd16, 16'sd100, 4'd2);
    send_item(ACT_SPARE, 6'd4, 16'sd500, 4'd1);
    repeat (3) tick();
    send_item(ACT_CLEAR, 6'd0, 16'sd0, 4'd0);
    send_item(ACT_FIRE, 6'd5, 16'sd256, 4'd1);
    repeat (2) tick();
  endtask

  task automatic test_shape_limits();
    quiesce();
    write_reg(REG_SHAPE_LEN, 64'd0);
    send_item(ACT_FIRE, 6'd2, 16'sd1000, 4'd0);
    tick();
    quiesce();
    // over-long shape acts as sixteen samples
    write_reg(REG_SHAPE_LEN, 64'd31);
    // half steps to check round half up on both signs
    write_reg(REG_SHAPE_A, 64'hE000_2000_2000_2000);
    write_reg(REG_SHAPE_B, 64'h7FFF_7FFF_7FFF_7FFF);
    write_reg(REG_SHAPE_C, 64'h0000_FFFF_0001_8000);
    write_reg(REG_SHAPE_D, 64'h8000_8000_8000_8000);
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, 64'h1234_5678_9ABC_DEF0);
    write_reg(REG_SHUNT, 64'hFFFF_FFFF_FFFF_FFFE);
    send_item(ACT_FIRE, 6'd6, 16'sd1, 4'd0);
    send_item(ACT_FIRE, 6'd8, -16'sd1, 4'd0);
    send_item(ACT_FIRE, 6'd9, 16'sd3, 4'd0);
    repeat (2) tick();
  endtask

  task automatic test_random(input int n_items);
    int done;
    int r;
    logic [63:0] len;
    quiesce();
    r = $urandom_range(0, 9);
    len = {$urandom, $urandom} & ~64'h1F;
    if (r == 0) len[4:0] = 5'd0;
    else if (r == 1) len[4:0] = 5'($urandom_range(17, 31));
    else len[4:0] = 5'($urandom_range(1, 16));
    write_reg(REG_SHAPE_LEN, len);
    load_shape(0, 16'hFFFF);
    write_reg(REG_SHUNT, {$urandom, $urandom});
    done = 0;
    while (done < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        repeat ($urandom_range(1, 6)) begin
          send_item(ACT_FIRE,
                    ($urandom_range(0, 9) == 0) ? 6'($urandom_range(16, 63))
                                                : 6'($urandom_range(0, CELLS - 1)),
                    16'($urandom), 4'($urandom));
          done++;
        end
        repeat ($urandom_range(1, 3)) begin
          tick();
          done++;
        end
      end else if (r < 85) begin
        send_item(ACT_CLEAR, 6'($urandom), 16'($urandom), 4'($urandom));
        done++;
      end else if (r < 93) begin
        send_item(ACT_SPARE, 6'($urandom), 16'($urandom), 4'($urandom));
      end else begin
        repeat ($urandom_range(2, 5)) begin
          tick();
          done++;
        end
      end
    end
  endtask

  // a long run of strong spikes drives one cell to the upper rail in the frames
  // of the positive samples and to the lower rail in those of the negative ones
  task automatic test_saturation();
    logic [63:0] v;
    quiesce();
    write_reg(REG_SHAPE_LEN, 64'd16);
    // samples 0 to 7 near +2.0, samples 8 to 15 near -2.0
    for (int r = 0; r < 4; r++) begin
      for (int j = 0; j < 4; j++) begin
        v[16*j +: 16] = (r < 2) ? 16'($urandom_range(16'h7F00, 16'h7FFF))
                                : 16'($urandom_range(16'h8000, 16'h80FF));
      end
      write_reg(3'(REG_SHAPE_A + r), v);
    end
    write_reg(REG_SHUNT, 64'd0);
    send_item(ACT_CLEAR, 6'd0, 16'sd0, 4'd0);
    // delay zero so every frame of the ring takes each spike
    for (int i = 0; i < 132; i++) begin
      send_item(ACT_FIRE, 6'd2, 16'($urandom_range(32600, 32767)), 4'd0);
    end
    repeat (FRAMES) tick();
  endtask

  initial begin
    clear_ring();
    ring_head = 0;
    shape_len_q = 5'd1;
    foreach (shape_q[r]) shape_q[r] = '0;
    shunt_q = 1'b0;
    sender_idle_pct = 35;
    stall_pct = 54;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_basics();
    test_shape_limits();
    test_random(50);
    sender_idle_pct = 54;
    stall_pct = 35;
    test_random(50);
    sender_idle_pct = 0;
    stall_pct = 0;
    test_saturation();

    quiesce();
    if (mismatches == 0) begin
      $display("tb_spike_delay_accumulator: PASS");
    end else begin
      $display("tb_spike_delay_accumulator: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
design/sda_pkg.sv
design/sda_regs.sv
design/sda_ctrl.sv
design/sda_dp.sv
design/spike_delay_accumulator.sv
dv/tb_spike_delay_accumulator.sv
